@@ hdl/index_free_list_defines.svh @@
// Assertion helpers shared by the RTL of the index free list.
// Each macro expects clk and rst in scope.
`ifndef INDEX_FREE_LIST_DEFINES_SVH
`define INDEX_FREE_LIST_DEFINES_SVH

// Same-cycle implication.
`define IFL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("free list check failed");

// Implication checked in the following cycle.
`define IFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("free list check failed");

`endif

@@ hdl/ifl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ifl_pkg;

  localparam int ELEM_W     = 10;
  localparam int CNT_W      = 11;
  localparam int STATUS_W   = 3;
  localparam int WIDE_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FULL   = 3'd3,
    ST_LISTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_LOOK
  } state_t;

  localparam logic [CFG_IDX_W-1:0] REG_START_FULL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_SIZE  = 1'd1;

  localparam logic ACT_TAKE = 1'b0;
  localparam logic ACT_GIVE = 1'b1;

  localparam logic [CNT_W-1:0] LIST_SIZE_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ hdl/ifl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ifl_req_if;
  import ifl_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [ELEM_W-1:0] element;
  modport source (output valid, action, element, input ready);
  modport sink   (input valid, action, element, output ready);
endinterface

interface ifl_rsp_if;
  import ifl_pkg::*;
  logic                valid;
  logic                ready;
  logic [ELEM_W-1:0]   taken_index;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    free_count;
  modport source (output valid, taken_index, status, free_count, input ready);
  modport sink   (input valid, taken_index, status, free_count, output ready);
endinterface

`default_nettype wire

@@ hdl/index_free_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "index_free_list_defines.svh"

// Channel  Dir  Beat contents
// req      in   action (0 take, 1 give), element
// rsp      out  taken_index, status, free_count
// cfg      in   cfg_wen, cfg_index, cfg_data (write only)
//
// Each request is accepted in IDLE and resolved in LOOK: the link table is a single synchronous RAM,
// read on the accept edge and written back on the following edge.
// A new request is taken only when the previous one has resolved and the
// rsp register is empty or draining.
// Reset and every config write run an init sweep over the first size table entries,
// size = list_size saturated to CAPACITY; req.ready stays low meanwhile.
// A stalled rsp beat holds in the output register.
module index_free_list #(
  parameter int CAPACITY = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [ifl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifl_pkg::CFG_DATA_W-1:0] cfg_data,
  ifl_req_if.sink                        req,
  ifl_rsp_if.source                      rsp
);
  import ifl_pkg::*;

  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] NONE  = LINK_W'(CAPACITY);
  localparam logic [WIDE_W-1:0] CAP_W = WIDE_W'(CAPACITY);

  // Table word: {listed, next link}
  logic [LINK_W:0] mem [CAPACITY];
  logic [LINK_W:0] rd_word;

  state_t            state, state_next;
  logic              start_full;
  logic [CNT_W-1:0]  list_size;
  logic [LINK_W-1:0] init_cnt;
  logic [LINK_W-1:0] head, head_next;
  logic [LINK_W-1:0] count, count_next;
  logic              req_give;
  logic [ELEM_W-1:0] req_elem;

  logic                out_valid;
  logic [ELEM_W-1:0]   out_taken;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_count;

  logic [WIDE_W-1:0] n_w;
  logic [WIDE_W-1:0] init_w;
  logic              init_last;
  logic              in_ready;
  logic              accept;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W:0]   mem_wdata;
  status_t           res_status;
  logic [ELEM_W-1:0] res_taken;

  assign n_w       = (WIDE_W'(list_size) > CAP_W) ? CAP_W : WIDE_W'(list_size);
  assign init_w    = WIDE_W'(init_cnt);
  assign init_last = (init_w + WIDE_W'(1)) >= n_w;
  assign accept    = req.valid && in_ready;
  assign req.ready = in_ready;
  assign rd_addr   = (req.action == ACT_GIVE) ? AW'(req.element) : head[AW-1:0];

  assign rsp.valid       = out_valid;
  assign rsp.taken_index = out_taken;
  assign rsp.status      = out_status;
  assign rsp.free_count  = out_count;

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
    if (cfg_wen) state_next = S_INIT;
  end

  always_comb begin
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = init_cnt[AW-1:0];
    mem_wdata  = {1'b0, NONE};
    res_status = ST_OK;
    res_taken  = '0;
    head_next  = head;
    count_next = count;
    case (state)
      S_INIT: begin
        mem_we = init_w < n_w;
        if (start_full && (init_w + WIDE_W'(1)) < n_w) begin
          mem_wdata = {1'b1, init_cnt + LINK_W'(1)};
        end else if (start_full) begin
          mem_wdata = {1'b1, NONE};
        end
      end
      S_IDLE: begin
        in_ready = !out_valid || rsp.ready;
      end
      S_LOOK: begin
        if (req_give == ACT_TAKE) begin
          if (count == '0 || head == NONE) begin
            res_status = ST_EMPTY;
          end else begin
            res_taken  = ELEM_W'(head);
            head_next  = rd_word[LINK_W-1:0];
            count_next = count - LINK_W'(1);
            mem_we     = 1'b1;
            mem_waddr  = head[AW-1:0];
            mem_wdata  = {1'b0, NONE};
          end
        end else begin
          if (WIDE_W'(req_elem) >= n_w) begin
            res_status = ST_RANGE;
          end else if (WIDE_W'(count) >= n_w) begin
            res_status = ST_FULL;
          end else if (rd_word[LINK_W]) begin
            res_status = ST_LISTED;
          end else begin
            head_next  = LINK_W'(req_elem);
            count_next = count + LINK_W'(1);
            mem_we     = 1'b1;
            mem_waddr  = AW'(req_elem);
            mem_wdata  = {1'b1, head};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_cnt   <= '0;
      start_full <= 1'b1;
      list_size  <= LIST_SIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        init_cnt <= '0;
        case (cfg_index)
          REG_START_FULL: start_full <= cfg_data[0];
          REG_LIST_SIZE:  list_size  <= cfg_data;
          default: ;
        endcase
      end else if (state == S_INIT) begin
        init_cnt <= init_cnt + LINK_W'(1);
      end
      if (state == S_LOOK) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      head  <= (start_full && n_w != '0) ? '0 : NONE;
      count <= start_full ? LINK_W'(n_w) : '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
    if (accept) begin
      req_give <= req.action;
      req_elem <= req.element;
    end
    if (state == S_LOOK) begin
      out_taken  <= res_taken;
      out_status <= res_status;
      out_count  <= CNT_W'(count_next);
    end
  end

  `IFL_ASSERT_NEXT(a_accept_look, req.valid && req.ready && !cfg_wen, state == S_LOOK)
  `IFL_ASSERT_NEXT(a_look_result, state == S_LOOK, rsp.valid)
  `IFL_ASSERT_IMPLY(a_head_count, state == S_IDLE, (count == '0) == (head == NONE))
  `IFL_ASSERT_IMPLY(a_count_bound, state == S_IDLE, WIDE_W'(count) <= n_w)

endmodule

`default_nettype wire

@@ dv/tb_index_free_list.sv @@
`timescale 1ns / 1ps

module tb_index_free_list;
  import ifl_pkg::*;

  localparam int CAPACITY      = 1024;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_PRINTS    = 40;

  localparam logic [CNT_W-1:0] NO_LINK = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [ELEM_W-1:0] taken;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } free_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ifl_req_if req_ch ();
  ifl_rsp_if rsp_ch ();

  index_free_list #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #1 clk = ~clk;

  // Shadow of the free list.
  logic [CNT_W-1:0] link_tbl [CAPACITY];
  bit               in_list  [CAPACITY];
  logic [CNT_W-1:0] head_idx;
  logic [CNT_W-1:0] free_cnt;
  bit               cfg_full;
  logic [CNT_W-1:0] cfg_size;

  free_rsp_t expected_rsps[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        src_idle = 1'b1;
  bit        sink_idle = 1'b1;
  int        stall_left = 0;

  function automatic logic [CNT_W-1:0] managed_size();
    return (cfg_size > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cfg_size;
  endfunction

  function automatic void rebuild_list();
    logic [CNT_W-1:0] n;
    n = managed_size();
    for (int i = 0; i < CAPACITY; i++) begin
      link_tbl[i] = NO_LINK;
      in_list[i]  = 1'b0;
    end
    if (cfg_full && n != 0) begin
      for (int i = 0; i < n; i++) begin
        link_tbl[i] = (i + 1 < n) ? CNT_W'(i + 1) : NO_LINK;
        in_list[i]  = 1'b1;
      end
      head_idx = '0;
      free_cnt = n;
    end else begin
      head_idx = NO_LINK;
      free_cnt = '0;
    end
  endfunction

  function automatic free_rsp_t apply_request(logic act, logic [ELEM_W-1:0] elem);
    free_rsp_t        r;
    logic [CNT_W-1:0] n;
    n        = managed_size();
    r.taken  = '0;
    r.status = ST_OK;
    if (act == ACT_TAKE) begin
      if (free_cnt == 0 || head_idx >= NO_LINK) begin
        r.status = ST_EMPTY;
      end else begin
        r.taken           = head_idx[ELEM_W-1:0];
        head_idx          = link_tbl[r.taken];
        link_tbl[r.taken] = NO_LINK;
        in_list[r.taken]  = 1'b0;
        free_cnt          = free_cnt - CNT_W'(1);
      end
    end else begin
      if ({1'b0, elem} >= n) begin
        r.status = ST_RANGE;
      end else if (free_cnt >= n) begin
        r.status = ST_FULL;
      end else if (in_list[elem]) begin
        r.status = ST_LISTED;
      end else begin
        link_tbl[elem] = head_idx;
        in_list[elem]  = 1'b1;
        head_idx       = {1'b0, elem};
        free_cnt       = free_cnt + CNT_W'(1);
      end
    end
    r.count = free_cnt;
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random index in range whose membership equals want, or -1.
  function automatic int find_slot(bit want);
    int n;
    int start;
    int j;
    n = int'(managed_size());
    if (n == 0) return -1;
    start = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      j = (start + i) % n;
      if (in_list[j] == want) return j;
    end
    return -1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < MAX_PRINTS)
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic send_request(logic act, logic [ELEM_W-1:0] elem);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.element <= elem;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_rsps.push_back(apply_request(act, elem));
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int sweep;
    wait_drain();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_START_FULL) cfg_full = val[0];
    else cfg_size = val[CNT_W-1:0];
    rebuild_list();
    // Sit out the init sweep before anything else touches the block.
    sweep = (managed_size() == 0) ? 1 : int'(managed_size());
    repeat (sweep + SETTLE_CYCLES) @(posedge clk);
  endtask

  // Response sink with random back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (sink_idle && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst !== 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected beat, status", int'(rsp_ch.status), 0);
      end else begin
        free_rsp_t want;
        want = expected_rsps.pop_front();
        if (rsp_ch.taken_index !== want.taken)
          report_mismatch("taken_index", int'(rsp_ch.taken_index), int'(want.taken));
        if (rsp_ch.status !== want.status)
          report_mismatch("status", int'(rsp_ch.status), int'(want.status));
        if (rsp_ch.free_count !== want.count)
          report_mismatch("free_count", int'(rsp_ch.free_count), int'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Default config: all 1024 indices free. Covers the listed tail and full list.
  task automatic test_reset_full();
    send_request(ACT_TAKE, '0);
    send_request(ACT_TAKE, '1);
    send_request(ACT_GIVE, 10'd1);
    send_request(ACT_GIVE, 10'd1);
    send_request(ACT_GIVE, 10'd1023);
    send_request(ACT_GIVE, 10'd0);
    send_request(ACT_GIVE, 10'd5);
    send_request(ACT_TAKE, '0);
    wait_drain();
  endtask

  // Three entries: drain to empty, refill, full beats listed.
  task automatic test_small_full();
    write_reg(REG_LIST_SIZE, CFG_DATA_W'(3));
    repeat (4) send_request(ACT_TAKE, '0);
    send_request(ACT_GIVE, 10'd3);
    send_request(ACT_GIVE, 10'd0);
    send_request(ACT_GIVE, 10'd0);
    send_request(ACT_GIVE, 10'd2);
    send_request(ACT_GIVE, 10'd1);
    send_request(ACT_GIVE, 10'd1);
    wait_drain();
  endtask

  // Empty start with a lone entry.
  task automatic test_empty_single();
    write_reg(REG_START_FULL, CFG_DATA_W'(0));
    write_reg(REG_LIST_SIZE, CFG_DATA_W'(1));
    send_request(ACT_TAKE, '0);
    send_request(ACT_GIVE, 10'd1);
    send_request(ACT_GIVE, 10'd0);
    send_request(ACT_GIVE, 10'd0);
    send_request(ACT_TAKE, '0);
    wait_drain();
  endtask

  // No index managed at all, in both modes.
  task automatic test_size_zero();
    write_reg(REG_LIST_SIZE, CFG_DATA_W'(0));
    send_request(ACT_GIVE, 10'd0);
    write_reg(REG_START_FULL, CFG_DATA_W'(1));
    send_request(ACT_TAKE, '0);
    wait_drain();
  endtask

  task automatic run_random_phase(int items);
    int  r;
    int  slot;
    int  n;
    logic [ELEM_W-1:0] elem;
    for (int k = 0; k < items; k++) begin
      n    = int'(managed_size());
      r    = $urandom_range(0, 99);
      elem = ELEM_W'($urandom_range(0, CAPACITY - 1));
      if (r < 45) begin
        send_request(ACT_TAKE, elem);
      end else if (r < 85) begin
        slot = find_slot(1'b0);
        send_request(ACT_GIVE, (slot >= 0) ? ELEM_W'(slot) : elem);
      end else if (r < 92) begin
        send_request(ACT_GIVE, elem);
      end else if (r < 97) begin
        slot = find_slot(1'b1);
        send_request(ACT_GIVE, (slot >= 0) ? ELEM_W'(slot) : elem);
      end else begin
        // Just past the managed range.
        if (n + 3 < CAPACITY) elem = ELEM_W'(n + $urandom_range(0, 3));
        send_request(ACT_GIVE, elem);
      end
    end
  endtask

  task automatic test_random();
    bit               modes [10] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
    logic [CNT_W-1:0] sizes [10] = '{11'd1024, 11'd1024, 11'd1, 11'd2, 11'd16,
                                     11'd16, 11'd2047, 11'd1025, 11'd7, 11'd5};
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_START_FULL, CFG_DATA_W'(modes[p]));
      write_reg(REG_LIST_SIZE, sizes[p]);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      run_random_phase(35);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      run_random_phase(35);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    wait_drain();
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_wen        <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.action  <= ACT_TAKE;
    req_ch.element <= '0;
    cfg_full = 1'b1;
    cfg_size = LIST_SIZE_RESET;
    rebuild_list();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_full();
    test_small_full();
    test_empty_single();
    test_size_zero();
    test_random();

    wait_drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
